@@ rtl/icdf_pkg.sv @@
package icdf_pkg;

   // Width of the configuration write data and of the register index.
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_INDEX_WIDTH = 1;

   // Width of a CDF entry and of the random words.
   localparam int WORD_WIDTH = 32;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INTERVAL_COUNT = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANGLE_STEP     = 1'b1;

   // Request action codes.
   localparam logic ACT_LOAD   = 1'b0;
   localparam logic ACT_SAMPLE = 1'b1;

   // Two pi in Q3.29, which is also pi in Q2.30.
   localparam logic [WORD_WIDTH-1:0] TWO_PI_Q3_29 = 32'd3373259426;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_READ_LO,
      ST_TAKE_LO,
      ST_DIVIDE,
      ST_MUL_FRAC,
      ST_OUTPUT
   } icdf_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic start;
      logic search;
      logic pick;
      logic read_lo;
      logic take_lo;
      logic div_step;
      logic mul_frac;
      logic load_out;
   } icdf_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic search_done;
      logic div_skip;
      logic div_done;
      logic out_free;
   } icdf_sts_type;

endpackage

@@ rtl/icdf_ctrl.sv @@
module icdf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_action,
   input  icdf_pkg::icdf_sts_type sts,
   output logic                   req_stall,
   output icdf_pkg::icdf_cmd_type cmd
);
   import icdf_pkg::*;

   icdf_state_type state_ff;
   icdf_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_action == ACT_SAMPLE) begin
                  cmd.start = 1'b1;
                  state_in  = ST_SEARCH;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_SEARCH: begin
            if (sts.search_done) begin
               cmd.pick = 1'b1;
               state_in = ST_READ_LO;
            end else begin
               cmd.search = 1'b1;
            end
         end
         ST_READ_LO: begin
            cmd.read_lo = 1'b1;
            state_in    = ST_TAKE_LO;
         end
         ST_TAKE_LO: begin
            cmd.take_lo = 1'b1;
            if (sts.div_skip) begin
               state_in = ST_MUL_FRAC;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               state_in = ST_MUL_FRAC;
            end
         end
         ST_MUL_FRAC: begin
            cmd.mul_frac = 1'b1;
            state_in     = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/icdf_datapath.sv @@
module icdf_datapath #(
   parameter int MAX_INTERVALS = 1024,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  icdf_pkg::icdf_cmd_type                    cmd,
   output icdf_pkg::icdf_sts_type                    sts,
   input  logic                                      csr_wr_en,
   input  logic [icdf_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [icdf_pkg::CSR_DATA_WIDTH-1:0]       csr_wdata,
   input  logic [$clog2(MAX_INTERVALS)-1:0]          req_entry_index,
   input  logic [icdf_pkg::WORD_WIDTH-1:0]           req_cumulative_value,
   input  logic [icdf_pkg::WORD_WIDTH-1:0]           req_rand_theta,
   input  logic [icdf_pkg::WORD_WIDTH-1:0]           req_rand_phi,
   input  logic                                      rsp_stall,
   output logic                                      rsp_valid,
   output logic [$clog2(MAX_INTERVALS)-1:0]          rsp_interval_found,
   output logic [FRACTION_BITS-1:0]                  rsp_fraction,
   output logic [icdf_pkg::WORD_WIDTH-1:0]           rsp_theta,
   output logic [icdf_pkg::WORD_WIDTH-1:0]           rsp_phi,
   output logic                                      rsp_search_miss,
   output logic                                      rsp_zero_width
);
   import icdf_pkg::*;

   localparam int IW  = $clog2(MAX_INTERVALS);
   localparam int CW  = IW + 1;
   localparam int FB  = FRACTION_BITS;
   localparam int DCW = $clog2(FRACTION_BITS + 1);
   localparam int SW  = IW + WORD_WIDTH + 1;
   localparam int PW  = 2 * WORD_WIDTH;
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_INTERVALS);
   // Pi over the table depth, rounded to nearest, in Q2.30.
   localparam logic [WORD_WIDTH-1:0] ANGLE_STEP_RESET =
      WORD_WIDTH'((64'(TWO_PI_Q3_29) + 64'(MAX_INTERVALS / 2)) / 64'(MAX_INTERVALS));

   // CDF table.
   logic [WORD_WIDTH-1:0] cdf_mem [MAX_INTERVALS];
   logic [WORD_WIDTH-1:0] mem_q;

   // Configuration registers.
   logic [CW-1:0]         interval_count_ff, interval_count_in;
   logic [WORD_WIDTH-1:0] angle_step_ff, angle_step_in;

   // Search and interpolation registers.
   logic [CW-1:0]         n_ff, n_in;
   logic [CW-1:0]         base_ff, base_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [WORD_WIDTH-1:0] r_ff, r_in;
   logic [WORD_WIDTH-1:0] phi_word_ff, phi_word_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic                  miss_ff, miss_in;
   logic [WORD_WIDTH-1:0] hi_ff, hi_in;
   logic                  zero_ff, zero_in;
   logic [WORD_WIDTH-1:0] wid_ff, wid_in;
   logic [WORD_WIDTH-1:0] rem_ff, rem_in;
   logic [FB-1:0]         quo_ff, quo_in;
   logic [DCW-1:0]        div_cnt_ff, div_cnt_in;
   logic [IW+WORD_WIDTH-1:0] base_prod_ff, base_prod_in;
   logic [FB+WORD_WIDTH-1:0] frac_prod_ff, frac_prod_in;
   logic [WORD_WIDTH-1:0] phi_ff, phi_in;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]         out_idx_ff, out_idx_in;
   logic [FB-1:0]         out_frac_ff, out_frac_in;
   logic [WORD_WIDTH-1:0] out_theta_ff, out_theta_in;
   logic [WORD_WIDTH-1:0] out_phi_ff, out_phi_in;
   logic                  out_miss_ff, out_miss_in;
   logic                  out_zero_ff, out_zero_in;

   // Intermediate values.
   logic [CW-1:0]         n_clamp;
   logic [CW-1:0]         half;
   logic [CW-1:0]         n_minus_one;
   logic                  less;
   logic                  miss_now;
   logic [IW-1:0]         pick_idx;
   logic [WORD_WIDTH-1:0] lo_val;
   logic                  zero_now;
   logic [WORD_WIDTH-1:0] num_now;
   logic [WORD_WIDTH-1:0] width_now;
   logic                  over_now;
   logic [WORD_WIDTH:0]   rem2;
   logic [WORD_WIDTH:0]   rem_sub;
   logic                  fits;
   logic [CW-1:0]         rd_addr_w;
   logic                  rd_en;
   logic                  wr_en;
   logic [WORD_WIDTH-1:0] mul_a;
   logic [WORD_WIDTH-1:0] mul_b;
   logic [PW-1:0]         mul_p;
   logic [SW-1:0]         theta_sum;
   logic [WORD_WIDTH-1:0] theta_sat;
   logic                  rsp_take;

   // Table write on a load transaction; read with a registered output.
   assign wr_en = cmd.load && (CW'(req_entry_index) < MAX_COUNT);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cdf_mem[req_entry_index] <= req_cumulative_value;
      end
      if (rd_en) begin
         mem_q <= cdf_mem[rd_addr_w[IW-1:0]];
      end
   end

   // Search step and interval selection terms.
   always_comb begin
      if (interval_count_ff == '0) begin
         n_clamp = CW'(1);
      end else if (interval_count_ff > MAX_COUNT) begin
         n_clamp = MAX_COUNT;
      end else begin
         n_clamp = interval_count_ff;
      end
      half        = cnt_ff >> 1;
      n_minus_one = n_ff - CW'(1);
      less        = mem_q < r_ff;
      miss_now    = base_ff >= n_ff;
      pick_idx    = miss_now ? n_minus_one[IW-1:0] : base_ff[IW-1:0];
   end

   // Interval bounds and the restoring division step.
   always_comb begin
      lo_val    = (idx_ff == '0) ? '0 : mem_q;
      zero_now  = hi_ff <= lo_val;
      num_now   = (r_ff > lo_val) ? (r_ff - lo_val) : '0;
      width_now = hi_ff - lo_val;
      over_now  = num_now >= width_now;
      rem2      = {rem_ff, 1'b0};
      rem_sub   = rem2 - {1'b0, wid_ff};
      fits      = rem2 >= {1'b0, wid_ff};
   end

   // Shared multiplier: interval base angle, azimuth, fractional angle.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.read_lo) begin
         mul_a = WORD_WIDTH'(idx_ff);
         mul_b = angle_step_ff;
      end else if (cmd.take_lo) begin
         mul_a = phi_word_ff;
         mul_b = TWO_PI_Q3_29;
      end else if (cmd.mul_frac) begin
         mul_a = WORD_WIDTH'(quo_ff);
         mul_b = angle_step_ff;
      end
      mul_p = PW'(mul_a) * PW'(mul_b);
   end

   // Theta sum with saturation to the word.
   always_comb begin
      theta_sum = SW'(base_prod_ff) + SW'(frac_prod_ff >> FB);
      theta_sat = (|theta_sum[SW-1:WORD_WIDTH]) ? '1 : theta_sum[WORD_WIDTH-1:0];
   end

   assign rsp_take = rsp_valid_ff && !rsp_stall;

   // Next values of all registers.
   always_comb begin
      interval_count_in = interval_count_ff;
      angle_step_in     = angle_step_ff;
      n_in              = n_ff;
      base_in           = base_ff;
      cnt_in            = cnt_ff;
      r_in              = r_ff;
      phi_word_in       = phi_word_ff;
      idx_in            = idx_ff;
      miss_in           = miss_ff;
      hi_in             = hi_ff;
      zero_in           = zero_ff;
      wid_in            = wid_ff;
      rem_in            = rem_ff;
      quo_in            = quo_ff;
      div_cnt_in        = div_cnt_ff;
      base_prod_in      = base_prod_ff;
      frac_prod_in      = frac_prod_ff;
      phi_in            = phi_ff;
      rsp_valid_in      = rsp_valid_ff;
      out_idx_in        = out_idx_ff;
      out_frac_in       = out_frac_ff;
      out_theta_in      = out_theta_ff;
      out_phi_in        = out_phi_ff;
      out_miss_in       = out_miss_ff;
      out_zero_in       = out_zero_ff;
      rd_addr_w         = '0;

      // Configuration writes.
      if (csr_wr_en) begin
         if (csr_index == CSR_INTERVAL_COUNT) begin
            interval_count_in = csr_wdata[CW-1:0];
         end else if (csr_index == CSR_ANGLE_STEP) begin
            angle_step_in = csr_wdata[WORD_WIDTH-1:0];
         end
      end

      // A sample transaction opens the search over the whole range.
      if (cmd.start) begin
         n_in        = n_clamp;
         base_in     = '0;
         cnt_in      = n_clamp;
         r_in        = req_rand_theta;
         phi_word_in = req_rand_phi;
         rd_addr_w   = n_clamp >> 1;
      end

      // One bisection step, and the probe address of the next one.
      if (cmd.search) begin
         if (less) begin
            base_in = base_ff + half + CW'(1);
            cnt_in  = cnt_ff - half - CW'(1);
         end else begin
            cnt_in = half;
         end
         rd_addr_w = base_in + (cnt_in >> 1);
      end

      // Search over: select the interval and read its upper bound.
      if (cmd.pick) begin
         idx_in    = pick_idx;
         miss_in   = miss_now;
         rd_addr_w = CW'(pick_idx);
      end

      // Capture the upper bound and read the lower bound.
      if (cmd.read_lo) begin
         hi_in        = mem_q;
         base_prod_in = mul_p[IW+WORD_WIDTH-1:0];
         rd_addr_w    = (idx_ff == '0) ? '0 : (CW'(idx_ff) - CW'(1));
      end

      // Set up the division, or settle the fraction when no division is needed.
      if (cmd.take_lo) begin
         zero_in    = zero_now;
         wid_in     = width_now;
         rem_in     = num_now;
         div_cnt_in = DCW'(FB);
         phi_in     = mul_p[PW-1:WORD_WIDTH];
         if (zero_now) begin
            quo_in = '0;
         end else if (over_now) begin
            quo_in = '1;
         end else begin
            quo_in = '0;
         end
      end

      // One quotient bit per step.
      if (cmd.div_step) begin
         rem_in     = fits ? rem_sub[WORD_WIDTH-1:0] : rem2[WORD_WIDTH-1:0];
         quo_in     = {quo_ff[FB-2:0], fits};
         div_cnt_in = div_cnt_ff - DCW'(1);
      end

      if (cmd.mul_frac) begin
         frac_prod_in = mul_p[FB+WORD_WIDTH-1:0];
      end

      // Result register: a new result enters when the old one has left.
      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         out_idx_in   = idx_ff;
         out_frac_in  = quo_ff;
         out_theta_in = theta_sat;
         out_phi_in   = phi_ff;
         out_miss_in  = miss_ff;
         out_zero_in  = zero_ff;
      end
   end

   assign rd_en = (cmd.start || cmd.search || cmd.pick || cmd.read_lo) &&
                  (rd_addr_w < MAX_COUNT);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_count_ff <= MAX_COUNT;
         angle_step_ff     <= ANGLE_STEP_RESET;
         rsp_valid_ff      <= 1'b0;
      end else begin
         interval_count_ff <= interval_count_in;
         angle_step_ff     <= angle_step_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      base_ff      <= base_in;
      cnt_ff       <= cnt_in;
      r_ff         <= r_in;
      phi_word_ff  <= phi_word_in;
      idx_ff       <= idx_in;
      miss_ff      <= miss_in;
      hi_ff        <= hi_in;
      zero_ff      <= zero_in;
      wid_ff       <= wid_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      div_cnt_ff   <= div_cnt_in;
      base_prod_ff <= base_prod_in;
      frac_prod_ff <= frac_prod_in;
      phi_ff       <= phi_in;
      out_idx_ff   <= out_idx_in;
      out_frac_ff  <= out_frac_in;
      out_theta_ff <= out_theta_in;
      out_phi_ff   <= out_phi_in;
      out_miss_ff  <= out_miss_in;
      out_zero_ff  <= out_zero_in;
   end

   // Status to the controller.
   always_comb begin
      sts.search_done = (cnt_ff == '0);
      sts.div_skip    = zero_now || over_now;
      sts.div_done    = (div_cnt_ff == DCW'(1));
      sts.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_interval_found = out_idx_ff;
   assign rsp_fraction       = out_frac_ff;
   assign rsp_theta          = out_theta_ff;
   assign rsp_phi            = out_phi_ff;
   assign rsp_search_miss    = out_miss_ff;
   assign rsp_zero_width     = out_zero_ff;

endmodule

@@ rtl/inverse_cdf_angle_sampler_unit.sv @@
// Channel   Direction  Handshake          Payload
// req       in         req_valid/stall    action, entry_index, cumulative_value,
//                                         rand_theta, rand_phi
// rsp       out        rsp_valid/stall    interval_found, fraction, theta, phi,
//                                         search_miss, zero_width
// csr       in         csr_wr_en          csr_index, csr_wdata
//
// A load transaction is taken while the controller is idle and writes the table directly.
// A sample is accepted while idle, then bisects the table (10 or 11 steps for 1024
// intervals, one table read each), picks the interval, reads its two bounds, runs the
// divider for FRACTION_BITS quotient bits (one quotient bit per cycle) unless the fraction
// needs no division, scales the fraction by the angle step and loads the result register;
// the next request is taken in the cycle after the result register is loaded.
// Reset is synchronous and clears the controller and the result valid, and sets the two
// configuration registers to their reset values. The table is not cleared. A waiting
// result does not hold up the next request, but a finished sample holds in its last
// state until the result register is free.
module inverse_cdf_angle_sampler_unit #(
   parameter int MAX_INTERVALS = 1024,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [icdf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [icdf_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_action,
   input  logic [$clog2(MAX_INTERVALS)-1:0]     req_entry_index,
   input  logic [icdf_pkg::WORD_WIDTH-1:0]      req_cumulative_value,
   input  logic [icdf_pkg::WORD_WIDTH-1:0]      req_rand_theta,
   input  logic [icdf_pkg::WORD_WIDTH-1:0]      req_rand_phi,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [$clog2(MAX_INTERVALS)-1:0]     rsp_interval_found,
   output logic [FRACTION_BITS-1:0]             rsp_fraction,
   output logic [icdf_pkg::WORD_WIDTH-1:0]      rsp_theta,
   output logic [icdf_pkg::WORD_WIDTH-1:0]      rsp_phi,
   output logic                                 rsp_search_miss,
   output logic                                 rsp_zero_width
);
   import icdf_pkg::*;

   icdf_cmd_type cmd;
   icdf_sts_type sts;

   // Sequencer for load and sample transactions.
   icdf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .sts        (sts),
      .req_stall  (req_stall),
      .cmd        (cmd)
   );

   // Table, search, divider, multiplier and result register.
   icdf_datapath #(
      .MAX_INTERVALS (MAX_INTERVALS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_entry_index      (req_entry_index),
      .req_cumulative_value (req_cumulative_value),
      .req_rand_theta       (req_rand_theta),
      .req_rand_phi         (req_rand_phi),
      .rsp_stall            (rsp_stall),
      .rsp_valid            (rsp_valid),
      .rsp_interval_found   (rsp_interval_found),
      .rsp_fraction         (rsp_fraction),
      .rsp_theta            (rsp_theta),
      .rsp_phi              (rsp_phi),
      .rsp_search_miss      (rsp_search_miss),
      .rsp_zero_width       (rsp_zero_width)
   );

endmodule
